[sv/tps_pkg.sv]
// Package for the texel partition selector: types, codes and hash step functions.
`default_nettype none

package tps_pkg;

  // Partition count codes used by the selection logic
  localparam logic [2:0] PC_ONE   = 3'd1;
  localparam logic [2:0] PC_THREE = 3'd3;
  localparam logic [2:0] PC_FOUR  = 3'd4;

  // Number of register stages from input to result
  localparam int PIPE_DEPTH = 7;

  // Texel coordinate after optional doubling
  typedef struct packed {
    logic [4:0] x;
    logic [4:0] y;
    logic [3:0] z;
  } coord_t;

  // Control bits that pick the seed shift amounts
  typedef struct packed {
    logic odd;    // pattern seed bit 0
    logic bit1;   // pattern seed bit 1
    logic bit4;   // pattern seed bit 4
    logic three;  // partition count is three
  } wctl_t;

  // Mixing hash, steps 1 and 2
  function automatic logic [31:0] mix_s1(input logic [31:0] p);
    logic [31:0] q;
    q = p ^ (p >> 15);
    q = q - (q << 17);
    return q;
  endfunction

  // Mixing hash, steps 3 and 4
  function automatic logic [31:0] mix_s2(input logic [31:0] p);
    logic [31:0] q;
    q = p + (p << 7);
    q = q + (q << 4);
    return q;
  endfunction

  // Mixing hash, steps 5 and 6
  function automatic logic [31:0] mix_s3(input logic [31:0] p);
    logic [31:0] q;
    q = p ^ (p >> 5);
    q = q + (q << 16);
    return q;
  endfunction

  // Mixing hash, closing xor-shift steps
  function automatic logic [31:0] mix_s4(input logic [31:0] p);
    logic [31:0] q;
    q = p ^ (p >> 7);
    q = q ^ (q >> 3);
    q = q ^ (q << 6);
    q = q ^ (q >> 17);
    return q;
  endfunction

  // Square of a 4-bit seed nibble
  function automatic logic [7:0] sq4(input logic [3:0] n);
    return {4'd0, n} * {4'd0, n};
  endfunction

endpackage

`default_nettype wire

[sv/tps_weights.sv]
// Seed weights: twelve hash nibbles squared and shifted right.
`default_nettype none

module tps_weights (
  input  wire logic [31:0]       hash,
  input  wire tps_pkg::wctl_t    ctl,
  output logic      [11:0][3:0]  weight
);

  logic [11:0][3:0] nib;
  logic [2:0]       sh1;
  logic [2:0]       sh2;
  logic [2:0]       sh3;
  logic [7:0]       sq [12];

  // Nibble taps of the hash; the last one wraps round the word
  assign nib[0]  = hash[3:0];
  assign nib[1]  = hash[7:4];
  assign nib[2]  = hash[11:8];
  assign nib[3]  = hash[15:12];
  assign nib[4]  = hash[19:16];
  assign nib[5]  = hash[23:20];
  assign nib[6]  = hash[27:24];
  assign nib[7]  = hash[31:28];
  assign nib[8]  = hash[21:18];
  assign nib[9]  = hash[25:22];
  assign nib[10] = hash[29:26];
  assign nib[11] = {hash[1:0], hash[31:30]};

  // Shift amounts from seed bits 0, 1 and 4 and the count
  always_comb begin
    if (ctl.odd) begin
      sh1 = ctl.bit1  ? 3'd4 : 3'd5;
      sh2 = ctl.three ? 3'd6 : 3'd5;
    end else begin
      sh1 = ctl.three ? 3'd6 : 3'd5;
      sh2 = ctl.bit1  ? 3'd4 : 3'd5;
    end
    sh3 = ctl.bit4 ? sh1 : sh2;
  end

  // Square, then shift: even taps by sh1, odd by sh2, the top four by sh3
  always_comb begin
    for (int i = 0; i < 12; i++) begin
      sq[i] = tps_pkg::sq4(nib[i]);
      if (i >= 8) begin
        weight[i] = 4'(sq[i] >> sh3);
      end else if ((i % 2) == 0) begin
        weight[i] = 4'(sq[i] >> sh1);
      end else begin
        weight[i] = 4'(sq[i] >> sh2);
      end
    end
  end

endmodule

`default_nettype wire

[sv/texel_partition_select_top.sv]
// Top level of the texel partition selector: seven-stage pipeline.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  pattern_seed, texel_x, texel_y, texel_z,
//                                           partition_count, dbl_coords
//  out      output     out_valid/out_stall  partition_index
//
// One texel per cycle while out_stall is low.
// The mixing hash takes four stages, at most two adders each; the weights,
// the sums and the compare take one stage each.
// Reset (rst, synchronous) clears only the stage valid bits.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up under a stall and in_stall rises only when every stage is full.
`default_nettype none

module texel_partition_select_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [9:0] pattern_seed,
  input  wire logic [3:0] texel_x,
  input  wire logic [3:0] texel_y,
  input  wire logic [2:0] texel_z,
  input  wire logic [2:0] partition_count,
  input  wire logic       dbl_coords,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      partition_index
);

  localparam int D = tps_pkg::PIPE_DEPTH;

  logic [D-1:0] v;
  logic [D-1:0] en;

  // Input decode
  logic [31:0]     seed_in;
  tps_pkg::coord_t coord_in;
  tps_pkg::wctl_t  ctl_in;

  // Stage registers
  logic [31:0]      h0, h1, h2, h3;
  tps_pkg::coord_t  coord0, coord1, coord2, coord3, coord4;
  logic [2:0]       cnt0, cnt1, cnt2, cnt3, cnt4, cnt5, cnt6;
  tps_pkg::wctl_t   ctl0, ctl1, ctl2, ctl3;
  logic [11:0][3:0] w4;
  logic [17:0]      hb4;
  logic [5:0]       sum_a5, sum_b5, sum_c5, sum_d5;

  // Combinational results
  logic [11:0][3:0] w_next;
  logic [5:0]       sa, sb, sc, sd;
  logic [1:0]       pidx_next;

  // Load enables: a stage takes new data when empty or draining
  always_comb begin
    en[D-1] = !v[D-1] || !out_stall;
    for (int k = D - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[D-1];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < D; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Seed plus (count - 1) * 1024: the offset has no low bits, so no carry
  always_comb begin
    seed_in    = {22'(partition_count) - 22'd1, pattern_seed};
    coord_in.x = dbl_coords ? {texel_x, 1'b0} : {1'b0, texel_x};
    coord_in.y = dbl_coords ? {texel_y, 1'b0} : {1'b0, texel_y};
    coord_in.z = dbl_coords ? {texel_z, 1'b0} : {1'b0, texel_z};
    ctl_in.odd   = pattern_seed[0];
    ctl_in.bit1  = pattern_seed[1];
    ctl_in.bit4  = pattern_seed[4];
    ctl_in.three = (partition_count == tps_pkg::PC_THREE);
  end

  // Weights from the finished hash
  tps_weights u_weights (
    .hash   (h3),
    .ctl    (ctl3),
    .weight (w_next)
  );

  // Weighted sums, kept to six bits; unused partitions forced to zero
  always_comb begin
    sa = 6'({5'd0, w4[0]} * {4'd0, coord4.x}) + 6'({5'd0, w4[1]} * {4'd0, coord4.y})
       + 6'({5'd0, w4[10]} * {5'd0, coord4.z}) + hb4[17:12];
    sb = 6'({5'd0, w4[2]} * {4'd0, coord4.x}) + 6'({5'd0, w4[3]} * {4'd0, coord4.y})
       + 6'({5'd0, w4[11]} * {5'd0, coord4.z}) + hb4[13:8];
    sc = 6'({5'd0, w4[4]} * {4'd0, coord4.x}) + 6'({5'd0, w4[5]} * {4'd0, coord4.y})
       + 6'({5'd0, w4[8]} * {5'd0, coord4.z}) + hb4[9:4];
    sd = 6'({5'd0, w4[6]} * {4'd0, coord4.x}) + 6'({5'd0, w4[7]} * {4'd0, coord4.y})
       + 6'({5'd0, w4[9]} * {5'd0, coord4.z}) + hb4[5:0];
    if (cnt4 < tps_pkg::PC_FOUR) begin
      sd = '0;
    end
    if (cnt4 < tps_pkg::PC_THREE) begin
      sc = '0;
    end
  end

  // Largest sum wins, ties to the lower index; a single partition is 0
  always_comb begin
    priority if (cnt5 == tps_pkg::PC_ONE) begin
      pidx_next = 2'd0;
    end else if (sum_a5 >= sum_b5 && sum_a5 >= sum_c5 && sum_a5 >= sum_d5) begin
      pidx_next = 2'd0;
    end else if (sum_b5 >= sum_c5 && sum_b5 >= sum_d5) begin
      pidx_next = 2'd1;
    end else if (sum_c5 >= sum_d5) begin
      pidx_next = 2'd2;
    end else begin
      pidx_next = 2'd3;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (en[0]) begin
      h0     <= tps_pkg::mix_s1(seed_in);
      coord0 <= coord_in;
      cnt0   <= partition_count;
      ctl0   <= ctl_in;
    end
    if (en[1]) begin
      h1     <= tps_pkg::mix_s2(h0);
      coord1 <= coord0;
      cnt1   <= cnt0;
      ctl1   <= ctl0;
    end
    if (en[2]) begin
      h2     <= tps_pkg::mix_s3(h1);
      coord2 <= coord1;
      cnt2   <= cnt1;
      ctl2   <= ctl1;
    end
    if (en[3]) begin
      h3     <= tps_pkg::mix_s4(h2);
      coord3 <= coord2;
      cnt3   <= cnt2;
      ctl3   <= ctl2;
    end
    if (en[4]) begin
      w4     <= w_next;
      hb4    <= h3[19:2];
      coord4 <= coord3;
      cnt4   <= cnt3;
    end
    if (en[5]) begin
      sum_a5 <= sa;
      sum_b5 <= sb;
      sum_c5 <= sc;
      sum_d5 <= sd;
      cnt5   <= cnt4;
    end
    if (en[6]) begin
      partition_index <= pidx_next;
      cnt6            <= cnt5;
    end
  end

`ifndef ASSERT_OFF
  // Input is held back only when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&v))
    else $error("input stalled with a free stage");

  // An open output lets the whole pipe move
  a_open_flow: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is open");

  // Index three needs four or more partitions, index two three or more
  a_index_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (partition_index != 2'd3 || cnt6 >= tps_pkg::PC_FOUR)
               && (partition_index != 2'd2 || cnt6 >= tps_pkg::PC_THREE))
    else $error("partition index beyond partition count");

  // Pipe is empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

[tb/tb_texel_partition_select_top.sv]
// Self-checking testbench for the texel partition selector: scoreboard, drivers and watchdog.
`timescale 1ns / 1ps

module tb_texel_partition_select_top;

  // Cycles with no transfer on either channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 700;
  localparam int QUIET_FROM     = 620;

  // One texel request as seen at the input channel
  typedef struct packed {
    logic [9:0] seed;
    logic [3:0] x;
    logic [3:0] y;
    logic [2:0] z;
    logic [2:0] cnt;
    logic       small_blk;
  } texel_req_t;

  typedef struct packed {
    texel_req_t req;
    logic [1:0] index;
  } pending_index_t;

  // Scoreboard: predicts the partition of each transfer in, checks each transfer out
  class partition_scoreboard;
    pending_index_t pending_index[$];
    int             errors = 0;

    function logic [31:0] hash_mix(logic [31:0] v);
      v = v ^ (v >> 15);
      v = v - (v << 17);
      v = v + (v << 7);
      v = v + (v << 4);
      v = v ^ (v >> 5);
      v = v + (v << 16);
      v = v ^ (v >> 7);
      v = v ^ (v >> 3);
      v = v ^ (v << 6);
      v = v ^ (v >> 17);
      return v;
    endfunction

    function logic [1:0] predict_index(texel_req_t r);
      logic [31:0] key;
      logic [31:0] h;
      logic [31:0] cx, cy, cz;
      logic [31:0] w [12];
      logic [31:0] sh1, sh2, sh3;
      logic [31:0] sum_a, sum_b, sum_c, sum_d;
      if (r.cnt == tps_pkg::PC_ONE) return 2'd0;
      cx = {28'd0, r.x};
      cy = {28'd0, r.y};
      cz = {29'd0, r.z};
      if (r.small_blk) begin
        cx = cx << 1;
        cy = cy << 1;
        cz = cz << 1;
      end
      // count offset wraps for a count of zero
      key = {22'd0, r.seed} + ({29'd0, r.cnt} - 32'd1) * 32'd1024;
      h = hash_mix(key);
      for (int i = 0; i < 8; i++) w[i] = (h >> (4 * i)) & 32'hF;
      w[8]  = (h >> 18) & 32'hF;
      w[9]  = (h >> 22) & 32'hF;
      w[10] = (h >> 26) & 32'hF;
      w[11] = ((h >> 30) | (h << 2)) & 32'hF;
      for (int i = 0; i < 12; i++) w[i] = w[i] * w[i];
      // shift amounts from the low seed bits and the count
      if (key[0]) begin
        sh1 = key[1] ? 32'd4 : 32'd5;
        sh2 = (r.cnt == tps_pkg::PC_THREE) ? 32'd6 : 32'd5;
      end else begin
        sh1 = (r.cnt == tps_pkg::PC_THREE) ? 32'd6 : 32'd5;
        sh2 = key[1] ? 32'd4 : 32'd5;
      end
      sh3 = key[4] ? sh1 : sh2;
      for (int i = 0; i < 8; i += 2) begin
        w[i]     = w[i] >> sh1;
        w[i + 1] = w[i + 1] >> sh2;
      end
      for (int i = 8; i < 12; i++) w[i] = w[i] >> sh3;
      sum_a = (w[0] * cx + w[1] * cy + w[10] * cz + (h >> 14)) & 32'h3F;
      sum_b = (w[2] * cx + w[3] * cy + w[11] * cz + (h >> 10)) & 32'h3F;
      sum_c = (w[4] * cx + w[5] * cy + w[8] * cz + (h >> 6)) & 32'h3F;
      sum_d = (w[6] * cx + w[7] * cy + w[9] * cz + (h >> 2)) & 32'h3F;
      if (r.cnt < tps_pkg::PC_FOUR) sum_d = 0;
      if (r.cnt < tps_pkg::PC_THREE) sum_c = 0;
      // largest sum wins, ties to the lower index
      if (sum_a >= sum_b && sum_a >= sum_c && sum_a >= sum_d) return 2'd0;
      if (sum_b >= sum_c && sum_b >= sum_d) return 2'd1;
      if (sum_c >= sum_d) return 2'd2;
      return 2'd3;
    endfunction

    function void note_transfer(texel_req_t r);
      pending_index_t p;
      p.req   = r;
      p.index = predict_index(r);
      pending_index.push_back(p);
    endfunction

    function void check_result(logic [1:0] got);
      pending_index_t p;
      if (pending_index.size() == 0) begin
        $display("%0t: unexpected partition_index %0d with nothing outstanding", $time, got);
        errors++;
        return;
      end
      p = pending_index.pop_front();
      if (got !== p.index) begin
        $display("%0t: partition_index mismatch: expected %0d, actual %0d",
                 $time, p.index, got);
        $display("  seed %0d x %0d y %0d z %0d cnt %0d small %0d",
                 p.req.seed, p.req.x, p.req.y, p.req.z, p.req.cnt, p.req.small_blk);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_index.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [9:0] pattern_seed = '0;
  logic [3:0] texel_x = '0;
  logic [3:0] texel_y = '0;
  logic [2:0] texel_z = '0;
  logic [2:0] partition_count = '0;
  logic       dbl_coords = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] partition_index;

  bit gaps_on    = 1'b1;
  bit quiet_tail = 1'b0;

  partition_scoreboard sb = new();

  texel_partition_select_top u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .pattern_seed    (pattern_seed),
    .texel_x         (texel_x),
    .texel_y         (texel_y),
    .texel_z         (texel_z),
    .partition_count (partition_count),
    .dbl_coords      (dbl_coords),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .partition_index (partition_index)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Monitor both channels at the edge; values seen are those before the edge
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sb.note_transfer({pattern_seed, texel_x, texel_y, texel_z, partition_count, dbl_coords});
    end
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(partition_index);
    end
  end

  // Present one texel and hold it until its transfer; optional gap in front
  task automatic drive_texel(input logic [9:0] seed, input logic [3:0] x, input logic [3:0] y,
                             input logic [2:0] z, input logic [2:0] cnt, input logic sm);
    if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    pattern_seed    <= seed;
    texel_x         <= x;
    texel_y         <= y;
    texel_z         <= z;
    partition_count <= cnt;
    dbl_coords      <= sm;
    do @(posedge clk); while (in_stall);
  endtask

  // Result side back-pressure in bursts
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, quiet_tail ? 1 : 30)) @(posedge clk);
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_texel_partition_select_top: done, errors");
    $finish;
  end

  // Main stimulus
  initial begin
    bit wide;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: single partition, field extremes, shift selections, odd counts
    drive_texel(10'd0,    4'd0,  4'd0,  3'd0, tps_pkg::PC_ONE,   1'b0);
    drive_texel(10'd1023, 4'd11, 4'd11, 3'd5, tps_pkg::PC_ONE,   1'b1);
    drive_texel(10'd0,    4'd0,  4'd0,  3'd0, 3'd2,              1'b0);
    drive_texel(10'd1023, 4'd11, 4'd11, 3'd5, tps_pkg::PC_FOUR,  1'b0);
    drive_texel(10'd1023, 4'd11, 4'd11, 3'd5, tps_pkg::PC_FOUR,  1'b1);
    drive_texel(10'd0,    4'd11, 4'd0,  3'd0, tps_pkg::PC_THREE, 1'b1);
    drive_texel(10'd1,    4'd0,  4'd11, 3'd0, 3'd2,              1'b0);
    drive_texel(10'd3,    4'd5,  4'd5,  3'd2, tps_pkg::PC_THREE, 1'b0);
    drive_texel(10'd2,    4'd7,  4'd3,  3'd1, tps_pkg::PC_THREE, 1'b1);
    drive_texel(10'd16,   4'd4,  4'd9,  3'd3, tps_pkg::PC_FOUR,  1'b0);
    drive_texel(10'd17,   4'd9,  4'd2,  3'd4, tps_pkg::PC_THREE, 1'b0);
    drive_texel(10'd19,   4'd1,  4'd10, 3'd5, tps_pkg::PC_FOUR,  1'b1);
    // count of zero wraps the offset
    drive_texel(10'd512,  4'd6,  4'd6,  3'd0, 3'd0,              1'b0);
    drive_texel(10'd1023, 4'd15, 4'd15, 3'd7, 3'd0,              1'b1);
    // counts above four behave as four for the sums
    drive_texel(10'd77,   4'd3,  4'd8,  3'd2, 3'd5,              1'b0);
    drive_texel(10'd400,  4'd10, 4'd1,  3'd4, 3'd6,              1'b1);
    drive_texel(10'd1023, 4'd15, 4'd15, 3'd7, 3'd7,              1'b1);
    // coordinates beyond the block
    drive_texel(10'd0,    4'd15, 4'd15, 3'd7, tps_pkg::PC_FOUR,  1'b0);
    drive_texel(10'd0,    4'd15, 4'd0,  3'd7, 3'd2,              1'b1);
    drive_texel(10'd345,  4'd12, 4'd13, 3'd6, tps_pkg::PC_THREE, 1'b0);
    drive_texel(10'd682,  4'd8,  4'd4,  3'd5, tps_pkg::PC_FOUR,  1'b1);
    drive_texel(10'd341,  4'd2,  4'd11, 3'd3, 3'd2,              1'b0);

    // random: mostly legal blocks, some full-width noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet_tail = (i >= QUIET_FROM);
      gaps_on    = ((i / 50) % 3 != 2);
      wide       = ($urandom_range(0, 6) == 0);
      if (wide) begin
        drive_texel(10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                    3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end else begin
        drive_texel(10'($urandom_range(0, 1023)), 4'($urandom_range(0, 11)),
                    4'($urandom_range(0, 11)), 3'($urandom_range(0, 5)),
                    3'($urandom_range(1, 4)), 1'($urandom_range(0, 1)));
      end
    end
    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (tps_pkg::PIPE_DEPTH * 3) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_texel_partition_select_top: done, clean");
    end else begin
      $display("tb_texel_partition_select_top: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
sv/tps_pkg.sv
sv/tps_weights.sv
sv/texel_partition_select_top.sv
tb/tb_texel_partition_select_top.sv
